[hdl/sfd_pkg.sv]
// sfd_pkg: shared types and constants for the sensor frame deframer
// no dependencies; used by sfd_cell and sensor_frame_deframer
`default_nettype none

package sfd_pkg;

   // frame geometry
   localparam int unsigned FrameLen  = 11;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned CountW    = 4;

   // header and trailer byte values
   localparam logic [ByteW-1:0] SyncByte = 8'h10;
   localparam logic [ByteW-1:0] TypeByte = 8'h64;   // 'd'
   localparam logic [ByteW-1:0] SepByte  = 8'h3A;   // ':'
   localparam logic [ByteW-1:0] EndByte  = 8'h00;

   // saturation point of the byte count and its last-byte threshold
   localparam logic [CountW-1:0] CountFull = CountW'(FrameLen);
   localparam logic [CountW-1:0] CountLast = CountW'(FrameLen - 1);

   // field widths of one result
   localparam int unsigned HumW   = 8;
   localparam int unsigned TempW  = 16;
   localparam int unsigned LightW = 32;
   localparam int unsigned RspW   = HumW + TempW + LightW;

   typedef logic [ByteW-1:0] byte_type;

   typedef struct packed {
      logic [LightW-1:0] light_raw;
      logic [TempW-1:0]  temp_tenths;
      logic [HumW-1:0]   humidity_pct;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/sfd_cell.sv]
// sfd_cell: one byte slot of the deframer shift window
// depends on sfd_pkg for the byte type
`default_nettype none

module sfd_cell (
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire sfd_pkg::byte_type data_in,
   input  wire sfd_pkg::byte_type expect_byte,
   output sfd_pkg::byte_type      data_out,
   output logic                   hit
);

   sfd_pkg::byte_type byte_ff;
   sfd_pkg::byte_type byte_in;

   // take the neighbor's byte on every accepted transfer
   assign byte_in = shift_en ? data_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // compare against this slot's expected byte value
   assign data_out = byte_ff;
   assign hit      = (byte_ff == expect_byte);

endmodule

`default_nettype wire

[hdl/sensor_frame_deframer.sv]
// sensor_frame_deframer: top level, eleven-cell byte window and result register
// depends on sfd_pkg and sfd_cell
//
//  channel | signals                         | payload
//  --------+---------------------------------+--------------------------------
//  req     | req_tvalid req_tready req_tdata | rx_byte
//  rsp     | rsp_tvalid rsp_tready rsp_tdata | humidity, temp tenths, light
//
// one byte per cycle while req_tready is high; the header check and the field
// pick are one level of logic in front of the result register, so a frame
// leaves in the cycle after its last byte. reset clears the byte count and the
// result valid; no frame can match until eleven bytes have arrived. req_tready
// drops only while a result is held and rsp_tready is low.
`default_nettype none

module sensor_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // [7:0] humidity_pct, [23:8] temp_tenths,
                                         // [55:24] light_raw
);

   localparam int unsigned N = sfd_pkg::FrameLen;

   // slots that carry a header byte ahead of the coming shift
   localparam logic [N-1:0] HdrMask = N'('b1110);

   sfd_pkg::byte_type win [N];
   sfd_pkg::byte_type expect_v [N];
   logic [N-1:0]      match_v;

   logic                        req_xfer;
   logic                        fire;
   logic                        hdr_ok;
   logic [sfd_pkg::CountW-1:0]  count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sfd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   assign req_xfer   = req_tvalid & req_tready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;

   // expected byte per slot, after the coming shift slot i+1 becomes slot i
   always_comb begin
      for (int i = 0; i < N; i++) begin
         expect_v[i] = sfd_pkg::EndByte;
      end
      expect_v[1] = sfd_pkg::SyncByte;
      expect_v[2] = sfd_pkg::TypeByte;
      expect_v[3] = sfd_pkg::SepByte;
   end

   // row of window cells, newest byte enters the top slot
   for (genvar g = 0; g < N; g++) begin : g_cell
      sfd_pkg::byte_type feed;
      if (g == N - 1) begin : g_top
         assign feed = req_tdata;
      end else begin : g_mid
         assign feed = win[g+1];
      end
      sfd_cell u_cell (
         .clock       (clock),
         .shift_en    (req_xfer),
         .data_in     (feed),
         .expect_byte (expect_v[g]),
         .data_out    (win[g]),
         .hit         (match_v[g])
      );
   end

   // header and trailer check on the window as it stands after this transfer
   assign hdr_ok = (&(match_v | ~HdrMask)) & (req_tdata == sfd_pkg::EndByte);
   assign fire   = req_xfer & hdr_ok & (count_ff >= sfd_pkg::CountLast);

   // bytes since last frame, saturating at the frame length
   always_comb begin
      count_in = count_ff;
      priority if (fire) begin
         count_in = '0;
      end else if (req_xfer && count_ff < sfd_pkg::CountFull) begin
         count_in = count_ff + 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_valid_in             = rsp_valid_ff & ~rsp_tready;
      if (fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.humidity_pct = win[4];
         rsp_data_in.temp_tenths  = {win[6], win[5]};
         rsp_data_in.light_raw    = {win[10], win[9], win[8], win[7]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
